@@ rtl/sdu_pkg.sv @@
// package for the s-box differential uniformity core
// holds table sizes, the shared command struct and the state enum; no dependencies
package sdu_pkg;
  localparam int SboxBits  = 8;
  localparam int TableSize = 1 << SboxBits;
  localparam int CountW    = SboxBits + 1;
  localparam int QDepth    = 2;

  typedef struct packed {
    logic [SboxBits-1:0] idx;
    logic [SboxBits-1:0] val;
    logic                in_range;
    logic                last;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_COUNT,
    S_SCAN,
    S_OUT
  } state_e;
endpackage

@@ rtl/sbox_differential_uniformity_core.sv @@
// differential uniformity core: entries load in one cycle each through a two-deep queue while it has room
// the last entry starts 255 passes of clear, count and scan over the histogram memory,
// one per nonzero input difference, after which the result is offered
// one table at a time; asynchronous active-low reset empties the queue and sequencer
// s-box contents are undefined after reset until written
module sbox_differential_uniformity_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // entry_index[7:0], entry_value[15:8]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // max_diff_count[8:0], zero fill
);
  logic cmd_valid, cmd_ready;
  sdu_pkg::cmd_t cmd;
  logic [sdu_pkg::CountW-1:0] res;

  sdu_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i), .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),  .s_tlast_i  (s_axis_tlast_i),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sdu_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .m_tvalid_o (m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_result_o (res)
  );

  assign m_axis_tdata_o = {(16 - sdu_pkg::CountW)'(0), res};
endmodule

@@ rtl/sdu_front.sv @@
// front end: accepts entry beats, classifies them, queues commands
// depends on sdu_pkg
module sdu_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [15:0]          s_tdata_i,
  input  logic                 s_tlast_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output sdu_pkg::cmd_t        cmd_o
);
  sdu_pkg::cmd_t q_mem [sdu_pkg::QDepth];
  logic wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic push, pop;
  sdu_pkg::cmd_t c;

  always_comb begin
    c.idx = s_tdata_i[sdu_pkg::SboxBits-1:0];
    c.val = s_tdata_i[8 +: sdu_pkg::SboxBits];
    c.in_range = (s_tdata_i[7:0] < 8'(sdu_pkg::TableSize - 1)) ||
                 (s_tdata_i[7:0] == 8'(sdu_pkg::TableSize - 1));
    c.last = s_tlast_i;
  end

  assign s_tready_o  = (cnt_q != 2'(sdu_pkg::QDepth));
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];
  assign wp_d  = push ? ~wp_q : wp_q;
  assign rp_d  = pop ? ~rp_q : rp_q;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(sdu_pkg::QDepth)) else $error("queue overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(sdu_pkg::QDepth)) |-> !push) else $error("push when full");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop when empty");
`endif
endmodule

@@ rtl/sdu_back.sv @@
// back end: s-box store, histogram memory and the uniformity sequencer
// depends on sdu_pkg
module sdu_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  sdu_pkg::cmd_t                 cmd_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [sdu_pkg::CountW-1:0]    m_result_o
);
  localparam int B = sdu_pkg::SboxBits;
  localparam int W = sdu_pkg::CountW;

  logic [B-1:0] sa [sdu_pkg::TableSize];
  logic [B-1:0] sb [sdu_pkg::TableSize];
  logic [W-1:0] hist [sdu_pkg::TableSize];

  sdu_pkg::state_e st_q, st_d;
  logic [B-1:0] d_q, d_d, x_q, x_d;
  logic [W-1:0] best_q, best_d;
  // count pipeline: stage 1 reads s-box, stage 2 reads hist, stage 3 writes
  logic         v1_q, v2_q;
  logic [B-1:0] ra_q, rb_q, od_q;
  logic [W-1:0] hrd_q;
  logic         fw_hit;
  logic [W-1:0] inc;
  logic         last_x;
  logic         sv_q;
  logic [W-1:0] scan_q;

  logic load;
  assign load = cmd_valid_i && (st_q == sdu_pkg::S_IDLE);
  assign cmd_ready_o = (st_q == sdu_pkg::S_IDLE);
  assign last_x = (x_q == B'(sdu_pkg::TableSize - 1));

  always_ff @(posedge clk_i) begin
    if (load && cmd_i.in_range) begin
      sa[cmd_i.idx] <= cmd_i.val;
      sb[cmd_i.idx] <= cmd_i.val;
    end
    ra_q <= sa[x_q];
    rb_q <= sb[x_q ^ d_q];
  end

  // od computed from registered s-box reads
  logic [B-1:0] od1;
  assign od1 = ra_q ^ rb_q;

  always_ff @(posedge clk_i) begin
    hrd_q <= hist[od1];
    od_q  <= od1;
    scan_q <= hist[x_q];
  end

  // back-to-back repeats of same bin forward last written value
  logic [W-1:0] wr_q;
  logic [B-1:0] wa_q;
  logic         wv_q;
  assign fw_hit = wv_q && (wa_q == od_q);
  assign inc = (fw_hit ? wr_q : hrd_q) + W'(1);

  always_ff @(posedge clk_i) begin
    if (st_q == sdu_pkg::S_CLEAR) hist[x_q] <= '0;
    else if (v2_q) hist[od_q] <= inc;
    wr_q <= inc;
    wa_q <= od_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; wv_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      v1_q <= (st_q == sdu_pkg::S_COUNT);
      v2_q <= v1_q;
      wv_q <= v2_q;
      sv_q <= (st_q == sdu_pkg::S_SCAN);
    end
  end

  always_comb begin
    st_d = st_q; d_d = d_q; x_d = x_q;
    best_d = best_q;
    if (sv_q && (scan_q > best_q)) best_d = scan_q;
    unique case (st_q)
      sdu_pkg::S_IDLE: begin
        if (load && cmd_i.last) begin
          st_d = sdu_pkg::S_CLEAR; d_d = B'(1); x_d = '0; best_d = '0;
        end
      end
      sdu_pkg::S_CLEAR: begin
        x_d = x_q + B'(1);
        if (last_x) st_d = sdu_pkg::S_COUNT;
      end
      sdu_pkg::S_COUNT: begin
        x_d = x_q + B'(1);
        if (last_x) st_d = sdu_pkg::S_SCAN;
      end
      sdu_pkg::S_SCAN: begin
        // scan holds its address until the pipeline has drained, but the histogram is read in every scan cycle
        if (!v1_q && !v2_q && !wv_q) begin
          x_d = x_q + B'(1);
          if (last_x) begin
            if (d_q == B'(sdu_pkg::TableSize - 1)) st_d = sdu_pkg::S_OUT;
            else begin
              st_d = sdu_pkg::S_CLEAR; d_d = d_q + B'(1);
            end
          end
        end
      end
      sdu_pkg::S_OUT: begin
        if (!sv_q && m_tready_i) st_d = sdu_pkg::S_IDLE;
      end
      default: st_d = sdu_pkg::S_IDLE;
    endcase
  end

  // sv_q flags the histogram read of every S_SCAN cycle, also those taken while the pipeline drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sdu_pkg::S_IDLE; d_q <= '0; x_q <= '0; best_q <= '0;
    end else begin
      st_q <= st_d; d_q <= d_d; x_q <= x_d; best_q <= best_d;
    end
  end

  always_comb begin
    m_tvalid_o = (st_q == sdu_pkg::S_OUT) && !sv_q;
    m_result_o = best_q;
  end

`ifndef SYNTHESIS
  a_nopipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == sdu_pkg::S_IDLE) |-> !v2_q) else $error("pipeline busy in idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> $stable(best_q)) else $error("result changed");
  a_noload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != sdu_pkg::S_IDLE) |-> !cmd_ready_o) else $error("load while busy");
`endif
endmodule
